// ===== design/smie_pkg.sv =====
package smie_pkg;

	localparam int DefStackDepth   = 1024;
	localparam int DefProgramDepth = 1024;

	typedef enum logic [3:0] {
		OP_PUSH  = 4'd0,
		OP_POP   = 4'd1,
		OP_DUP   = 4'd2,
		OP_SWAP  = 4'd3,
		OP_ADD   = 4'd4,
		OP_SUB   = 4'd5,
		OP_MUL   = 4'd6,
		OP_DIV   = 4'd7,
		OP_CMPE  = 4'd8,
		OP_CMPNE = 4'd9,
		OP_CMPG  = 4'd10,
		OP_CMPL  = 4'd11,
		OP_CJMP  = 4'd12,
		OP_JMP   = 4'd13,
		OP_PRINT = 4'd14,
		OP_NOP   = 4'd15
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_JUMP_OOB  = 3'd4,
		ST_EQ_WARN   = 3'd5
	} status_t;

	typedef struct packed {
		logic [3:0]         cmd;
		logic signed [31:0] operand;
	} in_item_t;

	typedef struct packed {
		logic [10:0]        next_pc;
		logic               print_valid;
		logic signed [31:0] print_value;
		logic [2:0]         status;
		logic               halted;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture input item, clear a and b
		logic rd_a;     // read top entry; unused, top is read whenever rd_b is low
		logic rd_b;     // read second entry
		logic cap_a;    // register read data as a
		logic cap_b;    // register read data as b
		logic div_go;   // start divider
		logic execute;  // evaluate and latch result
		logic wr;       // write one result entry
		logic commit;   // update count and pc
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_busy;
		logic is_div;
		logic fatal;
		logic [1:0] nres;
	} dp_stat_t;

	function automatic logic [1:0] pop_need(input logic [3:0] c);
		case (c)
			OP_PUSH, OP_JMP, OP_NOP: return 2'd0;
			OP_POP, OP_DUP, OP_CJMP, OP_PRINT: return 2'd1;
			default: return 2'd2;
		endcase
	endfunction

endpackage

// ===== design/smie_ram.sv =====
module smie_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== design/smie_div.sv =====
module smie_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [31:0] rem_q, quo_q, dvs_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;
	logic [31:0] ua, ub;

	assign ua = dividend[31] ? (32'd0 - dividend) : dividend;
	assign ub = divisor[31]  ? (32'd0 - divisor)  : divisor;
	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign busy = (cnt_q != 6'd0);
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= ua;
			dvs_q <= ub;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule

// ===== design/smie_datapath.sv =====
module smie_datapath #(
	parameter int StackDepth   = smie_pkg::DefStackDepth,
	parameter int ProgramDepth = smie_pkg::DefProgramDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smie_pkg::in_item_t  in_item,
	input  logic [10:0]         program_length,
	input  smie_pkg::dp_cmd_t   cmd_c,
	input  logic [1:0]          wr_idx,
	output smie_pkg::dp_stat_t  stat,
	output smie_pkg::out_item_t result
);
	import smie_pkg::*;

	localparam int AW = $clog2(StackDepth);
	localparam int CW = $clog2(StackDepth + 1);
	localparam int PW = $clog2(ProgramDepth + 1);

	logic [CW-1:0] cnt_q;
	logic [PW-1:0] pc_q;
	logic          halt_q;
	logic [3:0]    op_q;
	logic [31:0]   imm_q, a_q, b_q;
	logic [31:0]   res_q [3];
	logic [1:0]    nres_q;
	logic          fatal_q;
	logic [PW-1:0] next_q;
	logic [CW-1:0] base_q;
	logic [31:0]   rdata, prod_q, quo;
	out_item_t     res_out_q;

	logic [AW-1:0] raddr, waddr;
	logic          div_busy;
	logic [PW:0]   len;
	logic [CW-1:0] pops;

	always_comb begin
		if ({1'b0, program_length} > (PW+1)'(ProgramDepth) && PW + 1 <= 12)
			len = (PW+1)'(ProgramDepth);
		else if (PW + 1 > 12)
			len = (PW+1)'(program_length);
		else
			len = (PW+1)'(program_length);
		if ((PW+1) <= 12 && ProgramDepth < 2048 && {1'b0, program_length} > 12'(ProgramDepth))
			len = (PW+1)'(ProgramDepth);
	end

	assign pops  = CW'(pop_need(op_q));
	assign raddr = cmd_c.rd_b ? AW'(cnt_q - CW'(2)) : AW'(cnt_q - CW'(1));
	assign waddr = AW'(base_q + CW'(wr_idx));

	smie_ram #(.Width(32), .Depth(StackDepth)) u_stack (
		.clk   (clk),
		.we    (cmd_c.wr),
		.waddr (waddr),
		.wdata (res_q[wr_idx]),
		.raddr (raddr),
		.rdata (rdata)
	);

	smie_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd_c.div_go),
		.dividend (a_q),
		.divisor  (b_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd_c.load) begin
			op_q  <= in_item.cmd;
			imm_q <= in_item.operand;
			a_q   <= '0;
			b_q   <= '0;
		end
		if (cmd_c.cap_a) a_q <= rdata;
		if (cmd_c.cap_b) b_q <= rdata;
		prod_q <= a_q * b_q;
	end

	// evaluate the instruction
	logic          e_fatal, e_pv, e_jmp;
	logic [2:0]    e_st;
	logic [1:0]    e_n;
	logic [31:0]   e_r [3];
	logic [PW-1:0] e_next;
	logic          running;
	logic [CW+1:0] peak;

	always_comb begin
		running = !halt_q && ({1'b0, pc_q} < len);
		e_fatal = 1'b0; e_pv = 1'b0; e_st = ST_OK; e_n = 2'd0; e_jmp = 1'b0;
		e_r[0] = '0; e_r[1] = '0; e_r[2] = '0;
		e_next = pc_q + PW'(1);
		case (op_q)
			OP_PUSH: begin e_r[0] = imm_q; e_n = 2'd1; end
			OP_DUP: begin e_r[0] = a_q; e_r[1] = a_q; e_n = 2'd2; end
			OP_SWAP: begin e_r[0] = a_q; e_r[1] = b_q; e_n = 2'd2; end
			OP_ADD: begin e_r[0] = a_q + b_q; e_n = 2'd1; end
			OP_SUB: begin e_r[0] = a_q - b_q; e_n = 2'd1; end
			OP_MUL: begin e_r[0] = prod_q; e_n = 2'd1; end
			OP_DIV: begin
				if (b_q == '0) begin e_st = ST_DIVZERO; e_fatal = 1'b1; end
				else begin e_r[0] = quo; e_n = 2'd1; end
			end
			OP_CMPE, OP_CMPNE: begin
				e_r[0] = b_q; e_r[1] = a_q; e_n = 2'd3;
				e_r[2] = {31'd0, (a_q == b_q) ^ (op_q == OP_CMPNE)};
			end
			OP_CMPG, OP_CMPL: begin
				e_r[0] = a_q; e_r[1] = b_q; e_n = 2'd2;
				if (a_q == b_q) e_st = ST_EQ_WARN;
				else begin
					e_n = 2'd3;
					e_r[2] = {31'd0, (op_q == OP_CMPG) ? ($signed(a_q) > $signed(b_q))
						: ($signed(a_q) < $signed(b_q))};
				end
			end
			OP_CJMP, OP_JMP: begin
				e_jmp = (op_q == OP_JMP) || (a_q == 32'd1);
				if (e_jmp) begin
					if (imm_q[31] || {1'b0, imm_q} >= 33'(len)) begin
						e_st = ST_JUMP_OOB; e_fatal = 1'b1;
					end else e_next = PW'(imm_q);
				end
			end
			OP_PRINT: e_pv = 1'b1;
			default: ;
		endcase
		peak = (CW+2)'(cnt_q) - (CW+2)'(pops) + (CW+2)'(e_n);
		if (cnt_q < pops) begin
			e_st = ST_UNDERFLOW; e_fatal = 1'b1; e_pv = 1'b0;
		end else if (!e_fatal && peak > (CW+2)'(StackDepth)) begin
			e_st = ST_OVERFLOW; e_fatal = 1'b1; e_pv = 1'b0;
		end else if (e_fatal) e_pv = 1'b0;
		if (e_fatal) e_n = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd_c.execute) begin
			res_q[0] <= e_r[0]; res_q[1] <= e_r[1]; res_q[2] <= e_r[2];
			base_q <= cnt_q - pops;
			next_q <= (running && !e_fatal) ? e_next : pc_q;
			fatal_q <= !running || e_fatal;
			nres_q <= running ? e_n : 2'd0;
			res_out_q.next_pc     <= 11'((running && !e_fatal) ? e_next : pc_q);
			res_out_q.print_valid <= running && e_pv;
			res_out_q.print_value <= (running && e_pv) ? a_q : '0;
			res_out_q.status      <= running ? e_st : ST_OK;
			res_out_q.halted      <= !running || e_fatal || ({1'b0, e_next} >= len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; pc_q <= '0; halt_q <= 1'b0;
		end else if (cmd_c.commit) begin
			if (fatal_q) halt_q <= 1'b1;
			else begin
				cnt_q <= base_q + CW'(nres_q);
				pc_q  <= next_q;
				if ({1'b0, next_q} >= len) halt_q <= 1'b1;
			end
		end
	end

	assign result        = res_out_q;
	assign stat.div_busy = div_busy;
	assign stat.is_div   = (op_q == OP_DIV) && (cnt_q >= CW'(2)) && !halt_q;
	assign stat.fatal    = fatal_q;
	assign stat.nres     = nres_q;
endmodule

// ===== design/smie_ctrl.sv =====
module smie_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  smie_pkg::dp_stat_t stat,
	output smie_pkg::dp_cmd_t  cmd_c,
	output logic [1:0]         wr_idx
);
	import smie_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RDA, S_RDB, S_CAPB, S_DIV, S_EXEC, S_WRITE, S_DONE
	} state_t;

	state_t     state_q;
	logic [1:0] widx_q;
	logic       ovalid_q;

	// output register frees the next accept once the result is taken
	assign in_ready  = (state_q == S_IDLE) && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;
	assign wr_idx    = widx_q;

	always_comb begin
		cmd_c = '0;
		cmd_c.load    = (state_q == S_IDLE) && in_valid && in_ready;
		cmd_c.rd_b    = (state_q == S_RDA);
		cmd_c.cap_a   = (state_q == S_RDA);
		cmd_c.cap_b   = (state_q == S_RDB);
		cmd_c.div_go  = (state_q == S_CAPB) && stat.is_div;
		cmd_c.execute = (state_q == S_EXEC);
		cmd_c.wr      = (state_q == S_WRITE) && !stat.fatal && (widx_q < stat.nres);
		cmd_c.commit  = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; widx_q <= '0; ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd_c.load) state_q <= S_RDA;
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_CAPB;
				S_CAPB: state_q <= stat.is_div ? S_DIV : S_EXEC;
				S_DIV: if (!stat.div_busy) state_q <= S_EXEC;
				S_EXEC: begin state_q <= S_WRITE; widx_q <= '0; end
				S_WRITE: begin
					if (stat.fatal || widx_q + 2'd1 >= stat.nres) state_q <= S_DONE;
					else widx_q <= widx_q + 2'd1;
				end
				S_DONE: begin state_q <= S_IDLE; ovalid_q <= 1'b1; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_c.load |=> state_q == S_RDA) else $error("load did not start read");
	ap_no_ovalid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> out_valid) else $error("result not presented");
	ap_write_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_c.wr |-> widx_q < 2'd3) else $error("too many writes");
endmodule

// ===== design/stack_machine_instruction_executor_unit.sv =====
// Stack machine executor: one instruction per input transfer, one result per
// instruction. A non-divide instruction passes through two registered stack
// reads, capture, evaluate, up to three writes through the stack RAM's single
// write port and commit before its result is presented. The next instruction
// can be accepted from the cycle the result appears. A divide also waits on
// the bit-serial divider. The next instruction is taken once the previous
// result has left or is leaving the output register. No reset clearing pass.
module stack_machine_instruction_executor_unit #(
	parameter int StackDepth   = smie_pkg::DefStackDepth,
	parameter int ProgramDepth = smie_pkg::DefProgramDepth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  smie_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output smie_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [10:0]         cfg_wdata
);
	import smie_pkg::*;

	logic [10:0] plen_q;
	dp_cmd_t     cmd_c;
	dp_stat_t    stat;
	logic [1:0]  wr_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) plen_q <= '0;
		else if (cfg_we) plen_q <= cfg_wdata;
	end

	smie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat),
		.cmd_c(cmd_c), .wr_idx(wr_idx)
	);

	smie_datapath #(.StackDepth(StackDepth), .ProgramDepth(ProgramDepth)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .program_length(plen_q),
		.cmd_c(cmd_c), .wr_idx(wr_idx), .stat(stat), .result(out_data)
	);
endmodule

// ===== tb/sv/tb_stack_machine_instruction_executor_unit.sv =====
`timescale 1ns / 100ps

module tb_stack_machine_instruction_executor_unit;
	import smie_pkg::*;

	localparam int StkDepth = 1024;
	localparam int PrgDepth = 1024;
	localparam int Settle   = 60;

	typedef struct {
		bit [31:0] stk [0:StkDepth-1];
		int        cnt;
		int        pc;
		bit        halt;
		int        plen;
	} machine_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_wdata = '0;

	machine_t  gen_m;
	machine_t  model_m;
	in_item_t  pending_instrs[$];
	out_item_t expected_results[$];
	int        err_cnt = 0;
	int        instrs_taken = 0;
	int        results_seen = 0;
	int        prints_seen = 0;
	int        warns_seen = 0;
	bit        idle_on = 1'b1;
	bit        hold_req = 1'b0;
	bit        hold_done = 1'b0;
	int        send_gap = 0;
	int        recv_gap = 0;

	stack_machine_instruction_executor_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic int operands_taken(input logic [3:0] c);
		case (c)
			OP_PUSH, OP_JMP, OP_NOP: return 0;
			OP_POP, OP_DUP, OP_CJMP, OP_PRINT: return 1;
			default: return 2;
		endcase
	endfunction

	function automatic int eff_len(input int plen);
		return (plen > PrgDepth) ? PrgDepth : plen;
	endfunction

	// execute one instruction on a machine copy and return its result
	function automatic void run_instr(ref machine_t m, input in_item_t it,
			output out_item_t r);
		int        len;
		int        n;
		int        pops;
		int        nres;
		int        nxt;
		bit [31:0] a;
		bit [31:0] b;
		bit [31:0] opv;
		bit [31:0] res [0:2];
		bit        fatal;
		logic [2:0] st;
		bit        pv;
		bit [31:0] pval;
		longint    sa;
		longint    sb;
		len = eff_len(m.plen);
		nxt = m.pc;
		st = ST_OK;
		pv = 0;
		pval = 0;
		fatal = 0;
		nres = 0;
		opv = it.operand;
		if (m.halt || m.pc >= len) begin
			m.halt = 1;
		end else begin
			n = m.cnt;
			pops = operands_taken(it.cmd);
			a = (n >= 1) ? m.stk[n-1] : 32'd0;
			b = (n >= 2) ? m.stk[n-2] : 32'd0;
			sa = longint'($signed(a));
			sb = longint'($signed(b));
			nxt = m.pc + 1;
			case (it.cmd)
				OP_PUSH: begin res[0] = opv; nres = 1; end
				OP_DUP: begin res[0] = a; res[1] = a; nres = 2; end
				OP_SWAP: begin res[0] = a; res[1] = b; nres = 2; end
				OP_ADD: begin res[0] = a + b; nres = 1; end
				OP_SUB: begin res[0] = a - b; nres = 1; end
				OP_MUL: begin res[0] = a * b; nres = 1; end
				OP_DIV: begin
					if (b == 0) begin
						st = ST_DIVZERO;
						fatal = 1;
					end else begin
						res[0] = 32'(sa / sb);
						nres = 1;
					end
				end
				OP_CMPE: begin
					res[0] = b; res[1] = a; res[2] = {31'd0, a == b}; nres = 3;
				end
				OP_CMPNE: begin
					res[0] = b; res[1] = a; res[2] = {31'd0, a != b}; nres = 3;
				end
				OP_CMPG, OP_CMPL: begin
					res[0] = a; res[1] = b; nres = 2;
					if (a == b) begin
						st = ST_EQ_WARN;
					end else begin
						res[2] = (it.cmd == OP_CMPG) ? {31'd0, sa > sb} : {31'd0, sa < sb};
						nres = 3;
					end
				end
				OP_CJMP, OP_JMP: begin
					if (it.cmd == OP_JMP || a == 32'd1) begin
						if (opv[31] || opv >= 32'(len)) begin
							st = ST_JUMP_OOB;
							fatal = 1;
						end else begin
							nxt = int'(opv);
						end
					end
				end
				OP_PRINT: begin pv = 1; pval = a; end
				default: ;
			endcase
			if (n < pops) begin
				st = ST_UNDERFLOW; fatal = 1; pv = 0; pval = 0;
			end else if (!fatal && n - pops + nres > StkDepth) begin
				st = ST_OVERFLOW; fatal = 1; pv = 0; pval = 0;
			end else if (st == ST_JUMP_OOB || st == ST_DIVZERO) begin
				pv = 0; pval = 0;
			end
			if (fatal) begin
				m.halt = 1;
				nxt = m.pc;
			end else begin
				for (int i = 0; i < nres; i++)
					m.stk[n - pops + i] = res[i];
				m.cnt = n - pops + nres;
				m.pc = nxt;
				if (nxt >= len)
					m.halt = 1;
			end
		end
		r.next_pc = 11'(nxt);
		r.print_valid = pv;
		r.print_value = pval;
		r.status = st;
		r.halted = m.halt;
	endfunction

	task automatic put_instr(input logic [3:0] c, input logic [31:0] v);
		in_item_t  it;
		out_item_t dummy;
		it.cmd = c;
		it.operand = v;
		run_instr(gen_m, it, dummy);
		pending_instrs.push_back(it);
	endtask

	// jump back first when the next instruction would run off the program end;
	// land below the last address so the instruction itself cannot end the program
	task automatic put_guarded(input logic [3:0] c, input logic [31:0] v);
		int len;
		len = eff_len(gen_m.plen);
		if (!gen_m.halt && gen_m.pc == len - 1)
			put_instr(OP_JMP, $urandom_range(0, (len > 1) ? len - 2 : 0));
		put_instr(c, v);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			1: return 32'($urandom_range(0, 6)) - 32'd3;
			2: return 32'h7fff_ffff;
			3: return 32'h8000_0000;
			4: return 32'd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic put_random();
		int         r;
		int         len;
		int         n;
		logic [3:0] c;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		len = eff_len(gen_m.plen);
		n = gen_m.cnt;
		if (r < 10 && n < 1000) begin
			put_guarded(OP_PUSH, pick_word());
			put_guarded(OP_DUP, $urandom);
			put_guarded($urandom_range(0, 1) ? OP_CMPG : OP_CMPL, $urandom);
		end else if (r < 20 && n < 1000) begin
			put_guarded(OP_PUSH, 32'($urandom_range(0, 2)));
			put_guarded(OP_CJMP, $urandom_range(0, len - 1));
		end else begin
			c = 4'($urandom_range(0, 15));
			v = pick_word();
			if (operands_taken(c) > n)
				c = OP_PUSH;
			if (n >= 1000 && c inside {OP_PUSH, OP_DUP, OP_CMPE, OP_CMPNE, OP_CMPG, OP_CMPL})
				c = OP_POP;
			if (c == OP_DIV && gen_m.stk[n-2] == 0)
				c = OP_ADD;
			if (c == OP_JMP || (c == OP_CJMP && gen_m.stk[n-1] == 1))
				v = $urandom_range(0, len - 1);
			put_guarded(c, v);
		end
	endtask

	task automatic wait_drained();
		while (pending_instrs.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	task automatic write_length(input logic [10:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_m.plen = v;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!(in_valid && !in_ready)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_instrs.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= pending_instrs.pop_front();
				if (idle_on && $urandom_range(0, 3) == 0)
					send_gap <= $urandom_range(1, 16);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			recv_gap <= 400;
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 5) == 0)
				recv_gap <= $urandom_range(1, 16);
		end
	end

	// monitor: check results first, then predict for the new transfer
	always @(posedge clk) begin
		out_item_t e;
		out_item_t p;
		if (arst_n) begin
			if (cfg_we)
				model_m.plen = cfg_wdata;
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: %p", out_data);
					err_cnt++;
				end else begin
					e = expected_results.pop_front();
					if (out_data.next_pc !== e.next_pc) begin
						$error("next_pc exp %0d got %0d", e.next_pc, out_data.next_pc);
						err_cnt++;
					end
					if (out_data.print_valid !== e.print_valid) begin
						$error("print_valid exp %0b got %0b", e.print_valid,
							out_data.print_valid);
						err_cnt++;
					end
					if (out_data.print_value !== e.print_value) begin
						$error("print_value exp %0h got %0h", e.print_value,
							out_data.print_value);
						err_cnt++;
					end
					if (out_data.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, out_data.status);
						err_cnt++;
					end
					if (out_data.halted !== e.halted) begin
						$error("halted exp %0b got %0b", e.halted, out_data.halted);
						err_cnt++;
					end
					if (e.print_valid) prints_seen++;
					if (e.status == ST_EQ_WARN) warns_seen++;
				end
			end
			if (in_valid && in_ready) begin
				instrs_taken++;
				run_instr(model_m, in_data, p);
				expected_results.push_back(p);
			end
		end
	end

	initial begin
		#10ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		int scen;
		int len;
		gen_m.cnt = 0; gen_m.pc = 0; gen_m.halt = 0; gen_m.plen = 0;
		model_m.cnt = 0; model_m.pc = 0; model_m.halt = 0; model_m.plen = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: wrap cases, every opcode but pop, equal compares, cjmp taken and not
		write_length(11'd2047);
		put_guarded(OP_PUSH, 32'h7fff_ffff);
		put_guarded(OP_PUSH, 32'h8000_0000);
		put_guarded(OP_ADD, 0);
		put_guarded(OP_PUSH, 32'hffff_ffff);
		put_guarded(OP_PUSH, 32'h8000_0000);
		put_guarded(OP_DIV, 0);
		put_guarded(OP_DUP, 0);
		put_guarded(OP_SWAP, 0);
		put_guarded(OP_SUB, 0);
		put_guarded(OP_PUSH, 32'h0001_0003);
		put_guarded(OP_MUL, 0);
		put_guarded(OP_PUSH, 5);
		put_guarded(OP_PUSH, 5);
		put_guarded(OP_CMPG, 0);
		put_guarded(OP_CMPL, 0);
		put_guarded(OP_CMPE, 0);
		put_guarded(OP_CMPNE, 0);
		put_guarded(OP_PUSH, 1);
		put_guarded(OP_CJMP, 32'd40);
		put_guarded(OP_PUSH, 2);
		put_guarded(OP_CJMP, 32'hffff_ffff);
		put_guarded(OP_PRINT, 0);
		put_guarded(OP_NOP, 32'h5555_aaaa);
		put_guarded(OP_PUSH, 7);
		put_guarded(OP_JMP, 32'd0);
		wait_drained();

		write_length(11'd1024);
		for (int i = 0; i < 100; i++) put_random();
		hold_req = 1'b1;
		for (int i = 0; i < 100; i++) put_random();
		put_guarded(OP_JMP, 0);
		wait_drained();

		write_length(11'd2);
		for (int i = 0; i < 40; i++) put_random();
		put_guarded(OP_JMP, 0);
		wait_drained();

		write_length(11'($urandom_range(3, 1023)));
		for (int i = 0; i < 100; i++) put_random();
		put_guarded(OP_JMP, 0);
		wait_drained();

		// closing part: no idling, end in one fatal or end-of-program case chosen by the seed
		idle_on = 1'b0;
		write_length(11'd1024);
		for (int i = 0; i < 40; i++) put_random();
		scen = $urandom_range(0, 4);
		len = eff_len(gen_m.plen);
		case (scen)
			0: begin
				while (gen_m.cnt > 0) put_guarded(OP_POP, 0);
				put_guarded(OP_ADD, 0);
			end
			1: begin
				while (gen_m.cnt < StkDepth) put_guarded(OP_PUSH, $urandom);
				put_guarded(OP_PUSH, $urandom);
			end
			2: begin
				put_guarded(OP_PUSH, 0);
				put_guarded(OP_PUSH, pick_word());
				put_guarded(OP_DIV, 0);
			end
			3: put_guarded(OP_JMP, $urandom_range(0, 1) ? 32'(len + $urandom_range(0, 3000))
				: 32'h8000_0000 | $urandom);
			default: begin
				while (!gen_m.halt) put_instr(OP_NOP, $urandom);
			end
		endcase
		for (int i = 0; i < 3; i++) put_instr(4'($urandom_range(0, 15)), $urandom);
		wait_drained();
		write_length(11'd0);
		for (int i = 0; i < 3; i++) put_instr(4'($urandom_range(0, 15)), $urandom);
		wait_drained();

		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			err_cnt++;
		end
		$display("run covered %0d instructions and %0d results (%0d prints, %0d equal warnings)",
			instrs_taken, results_seen, prints_seen, warns_seen);
		$display("lengths 2047/1024/2/random/0, long output stall, closing fault case %0d", scen);
		if (err_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
